[rtl/mr1d_pkg.sv]
package mr1d_pkg;

    // Port plan: local ports first, then the left and right links
    localparam int LOCAL_PORTS = 4;
    localparam int NPORTS      = LOCAL_PORTS + 2;
    localparam int LEFT_P      = LOCAL_PORTS;
    localparam int RIGHT_P     = LOCAL_PORTS + 1;
    localparam int PIDX_W      = $clog2(NPORTS);
    localparam int LP_IDX_W    = (LOCAL_PORTS > 1) ? $clog2(LOCAL_PORTS) : 1;
    localparam int LP_POW2     = 1 << LP_IDX_W;

    // Field widths
    localparam int PORT_W = 3;
    localparam int CL_W   = 16;
    localparam int EL_W   = 16;
    localparam int DATA_W = 32;
    localparam int AGE_W  = 48;
    localparam int RDY_W  = 6;

    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 120;

    // Request / result kinds
    localparam logic KIND_RECV = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Register map (word index taken from paddr[ADDR_W-1:2])
    localparam int         ADDR_W           = 3;
    localparam logic [0:0] REG_NODE_CLUSTER = 1'b0;

    typedef struct packed {
        logic [CL_W-1:0]   cl;
        logic [EL_W-1:0]   el;
        logic [DATA_W-1:0] data;
        logic [AGE_W-1:0]  age;
    } pkt_t;

    typedef struct packed {
        logic              kind;
        logic [PORT_W-1:0] port;
        logic [CL_W-1:0]   cl;
        logic [EL_W-1:0]   el;
        logic [DATA_W-1:0] data;
        logic [AGE_W-1:0]  stamp;
        logic [RDY_W-1:0]  rdy;
    } item_t;

    // Everything one request produces, handed from the core to the result buffer
    typedef struct packed {
        logic                    tick;
        logic                    accepted;
        logic [PORT_W-1:0]       port;
        logic [NPORTS-1:0]       sent;
        pkt_t [NPORTS-1:0]       pkt;
    } res_t;

endpackage

[rtl/mesh1d_router_node_top.sv]
// Channel  | Dir | tdata (low bit up)                              | tuser    | tlast
// ---------+-----+-------------------------------------------------+----------+------
// s_axis   | in  | src_port, dest_cluster, dest_element, payload,  | req_type | -
//          |     | arrival_stamp, out_ready, zero pad to 128       |          |
// m_axis   | out | accepted, out_port, sent, sent_cluster,         | kind     | last
//          |     | sent_element, sent_payload, sent_stamp, pad 120 |          |
// apb      | in  | node_cluster at byte address 0                  | -        | -
//
// A request is registered on arrival and processed in the following cycle as soon as
// the result buffer is free; the state update is a single combinational pass.
// A receive request gives one result, so receives stream at one per clock unless stalled.
// A tick gives LOCAL_PORTS+2 results, one per clock on m_axis unless stalled, and holds
// the result buffer till the last is out; the next request waits in the input register.
// Stalls on m_axis back up into the input register and then s_tready.
// Reset clears tick count, all full flags and the input/result valid flags.
module mesh1d_router_node_top
    import mr1d_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // request stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // src_port, dest_cluster, dest_element,
                                              // payload, arrival_stamp, out_ready
    input  logic                   s_tuser,   // req_type
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // accepted, out_port, sent, sent_cluster,
                                              // sent_element, sent_payload, sent_stamp
    output logic                   m_tuser,   // kind
    output logic                   m_tlast,
    // register port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [CL_W-1:0]   node_cluster_reg;
    logic              in_valid_reg;
    item_t             in_item_reg;
    item_t             in_item_next;
    logic              go;
    logic              buf_free;
    res_t              core_res;
    logic              r_kind, r_accepted, r_sent, r_last;
    logic [PORT_W-1:0] r_port;
    pkt_t              r_pkt;

    // register port: word decode on paddr[ADDR_W-1:2]
    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1:2] == REG_NODE_CLUSTER) ? 32'(node_cluster_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            node_cluster_reg <= '0;
        else if (psel && penable && pwrite && pready
                 && (paddr[ADDR_W-1:2] == REG_NODE_CLUSTER))
            node_cluster_reg <= pwdata[CL_W-1:0];
    end

    // input register: refilled in the same cycle its request is processed
    assign go       = in_valid_reg && buf_free;
    assign s_tready = !in_valid_reg || go;

    always_comb
    begin
        in_item_next.kind  = s_tuser;
        in_item_next.port  = s_tdata[2:0];
        in_item_next.cl    = s_tdata[18:3];
        in_item_next.el    = s_tdata[34:19];
        in_item_next.data  = s_tdata[66:35];
        in_item_next.stamp = s_tdata[114:67];
        in_item_next.rdy   = s_tdata[120:115];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (go)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_item_reg <= in_item_next;
    end

    // router state and the routing pass
    mr1d_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .node_cluster (node_cluster_reg),
        .go           (go),
        .item         (in_item_reg),
        .res          (core_res)
    );

    // result buffer: holds one request's results and plays them out in port order
    mr1d_resbuf u_resbuf (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (go),
        .res_in       (core_res),
        .free         (buf_free),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_kind     (r_kind),
        .out_accepted (r_accepted),
        .out_port     (r_port),
        .out_sent     (r_sent),
        .out_pkt      (r_pkt),
        .out_last     (r_last)
    );

    assign m_tuser = r_kind;
    assign m_tlast = r_last;
    assign m_tdata = {3'b000, r_pkt.age, r_pkt.data, r_pkt.el, r_pkt.cl,
                      r_sent, r_port, r_accepted};

endmodule

[rtl/mr1d_core.sv]
module mr1d_core
    import mr1d_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [CL_W-1:0] node_cluster,
    input  logic            go,
    input  item_t           item,
    output res_t            res
);

    typedef enum logic [1:0] {SRC_NONE, SRC_LOC, SRC_RIGHT, SRC_LEFT} src_t;

    logic [AGE_W-1:0]  tick_reg,     tick_next;
    logic [NPORTS-1:0] in_full_reg,  in_full_next;
    logic [NPORTS-1:0] out_full_reg, out_full_next;
    pkt_t              in_pkt_reg  [NPORTS];
    pkt_t              in_pkt_next [NPORTS];
    pkt_t              out_pkt_reg  [NPORTS];
    pkt_t              out_pkt_next [NPORTS];

    // oldest local input
    logic                r_v;
    logic [LP_IDX_W-1:0] r_idx;
    logic [PIDX_W-1:0]   r_sel;
    pkt_t                r_pkt;

    always_comb
    begin
        logic                tv [LP_POW2];
        logic [LP_IDX_W-1:0] ti [LP_POW2];
        logic [AGE_W-1:0]    ta [LP_POW2];
        logic                take_b;
        for (int j = 0; j < LP_POW2; j++)
        begin
            ti[j] = LP_IDX_W'(j);
            if (j < LOCAL_PORTS)
            begin
                tv[j] = in_full_reg[j];
                ta[j] = in_pkt_reg[j].age;
            end
            else
            begin
                tv[j] = 1'b0;
                ta[j] = '0;
            end
        end
        // tournament, lower port kept on equal stamps
        for (int lvl = 0; lvl < LP_IDX_W; lvl++)
        begin
            for (int j = 0; j < (LP_POW2 >> (lvl + 1)); j++)
            begin
                take_b = tv[2*j+1] && (!tv[2*j] || (ta[2*j+1] < ta[2*j]));
                tv[j]  = tv[2*j] || tv[2*j+1];
                ti[j]  = take_b ? ti[2*j+1] : ti[2*j];
                ta[j]  = take_b ? ta[2*j+1] : ta[2*j];
            end
        end
        r_v   = tv[0];
        r_idx = ti[0];
    end

    assign r_sel = PIDX_W'(r_idx);
    assign r_pkt = in_pkt_reg[r_sel];

    function automatic src_t pick_lr(input logic a, input logic b, input logic a_lt_b,
                                     input src_t sa, input src_t sb);
        src_t s;
        if (a && b)
            s = a_lt_b ? sa : sb;
        else if (a)
            s = sa;
        else if (b)
            s = sb;
        else
            s = SRC_NONE;
        return s;
    endfunction

    always_comb
    begin
        logic [NPORTS-1:0] rdy_p;
        logic [NPORTS-1:0] out_busy;
        pkt_t              rp, lp;
        logic              r_lt_rr, r_lt_ll, rr_lt_ll;
        logic              r_taken, rr_taken, ll_taken;
        logic              ca, cb, cc, w_lt;
        src_t              s, w1, w2;
        pkt_t              mv;
        logic [PIDX_W-1:0] src_idx;

        tick_next     = tick_reg;
        in_full_next  = in_full_reg;
        out_full_next = out_full_reg;
        in_pkt_next   = in_pkt_reg;
        out_pkt_next  = out_pkt_reg;
        res           = '0;
        res.tick      = item.kind;
        res.port      = item.port;

        rdy_p    = NPORTS'(item.rdy);
        out_busy = out_full_reg;
        rp       = in_pkt_reg[RIGHT_P];
        lp       = in_pkt_reg[LEFT_P];
        r_lt_rr  = r_pkt.age < rp.age;
        r_lt_ll  = r_pkt.age < lp.age;
        rr_lt_ll = rp.age < lp.age;
        r_taken  = 1'b0;
        rr_taken = 1'b0;
        ll_taken = 1'b0;
        src_idx  = PIDX_W'(item.port);
        s        = SRC_NONE;
        w1       = SRC_NONE;
        w2       = SRC_NONE;
        ca       = 1'b0;
        cb       = 1'b0;
        cc       = 1'b0;
        w_lt     = 1'b0;
        mv       = '0;

        if (item.kind == KIND_RECV)
        begin
            if ((int'(item.port) < NPORTS) && !in_full_reg[src_idx])
            begin
                res.accepted             = 1'b1;
                in_full_next[src_idx]    = 1'b1;
                in_pkt_next[src_idx].cl  = item.cl;
                in_pkt_next[src_idx].el  = item.el;
                in_pkt_next[src_idx].data = item.data;
                in_pkt_next[src_idx].age = (int'(src_idx) < LOCAL_PORTS) ? tick_reg
                                                                          : item.stamp;
            end
        end
        else
        begin
            tick_next = tick_reg + 1'b1;

            // drain
            for (int i = 0; i < NPORTS; i++)
            begin
                res.sent[i] = out_full_reg[i] && rdy_p[i];
                res.pkt[i]  = res.sent[i] ? out_pkt_reg[i] : '0;
                if (res.sent[i])
                begin
                    out_full_next[i] = 1'b0;
                    out_busy[i]      = 1'b0;
                end
            end

            // left link output
            s = pick_lr(r_v && (r_pkt.cl > node_cluster),
                        in_full_reg[RIGHT_P] && (rp.cl > node_cluster),
                        r_lt_rr, SRC_LOC, SRC_RIGHT);
            if ((s != SRC_NONE) && !out_busy[LEFT_P])
            begin
                out_full_next[LEFT_P] = 1'b1;
                out_pkt_next[LEFT_P]  = (s == SRC_LOC) ? r_pkt : rp;
                if (s == SRC_LOC)
                begin
                    r_taken              = 1'b1;
                    in_full_next[r_sel]  = 1'b0;
                end
                else
                begin
                    rr_taken              = 1'b1;
                    in_full_next[RIGHT_P] = 1'b0;
                end
            end

            // right link output
            s = pick_lr(r_v && !r_taken && (r_pkt.cl < node_cluster),
                        in_full_reg[LEFT_P] && (lp.cl < node_cluster),
                        r_lt_ll, SRC_LOC, SRC_LEFT);
            if ((s != SRC_NONE) && !out_busy[RIGHT_P])
            begin
                out_full_next[RIGHT_P] = 1'b1;
                out_pkt_next[RIGHT_P]  = (s == SRC_LOC) ? r_pkt : lp;
                if (s == SRC_LOC)
                begin
                    r_taken             = 1'b1;
                    in_full_next[r_sel] = 1'b0;
                end
                else
                begin
                    ll_taken             = 1'b1;
                    in_full_next[LEFT_P] = 1'b0;
                end
            end

            // local outputs; each candidate matches one element at most
            for (int e = 0; e < LOCAL_PORTS; e++)
            begin
                ca = r_v && !r_taken && (r_pkt.cl == node_cluster)
                     && (r_pkt.el == EL_W'(e));
                cb = in_full_reg[RIGHT_P] && !rr_taken && (rp.cl == node_cluster)
                     && (rp.el == EL_W'(e));
                cc = in_full_reg[LEFT_P] && !ll_taken && (lp.cl == node_cluster)
                     && (lp.el == EL_W'(e));
                w1 = pick_lr(ca, cb, r_lt_rr, SRC_LOC, SRC_RIGHT);
                w2 = pick_lr(cb, cc, rr_lt_ll, SRC_RIGHT, SRC_LEFT);
                if ((w1 == SRC_LOC) && (w2 == SRC_RIGHT))
                    w_lt = r_lt_rr;
                else if ((w1 == SRC_LOC) && (w2 == SRC_LEFT))
                    w_lt = r_lt_ll;
                else if ((w1 == SRC_RIGHT) && (w2 == SRC_LEFT))
                    w_lt = rr_lt_ll;
                else
                    w_lt = 1'b0;
                s = pick_lr(w1 != SRC_NONE, w2 != SRC_NONE, w_lt, w1, w2);
                case (s)
                    SRC_LOC:   mv = r_pkt;
                    SRC_RIGHT: mv = rp;
                    SRC_LEFT:  mv = lp;
                    default:   mv = '0;
                endcase
                if ((s != SRC_NONE) && !out_busy[e])
                begin
                    out_full_next[e] = 1'b1;
                    out_pkt_next[e]  = mv;
                    case (s)
                        SRC_LOC:   in_full_next[r_sel]   = 1'b0;
                        SRC_RIGHT: in_full_next[RIGHT_P] = 1'b0;
                        SRC_LEFT:  in_full_next[LEFT_P]  = 1'b0;
                        default:   ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= '0;
            in_full_reg  <= '0;
            out_full_reg <= '0;
        end
        else if (go)
        begin
            tick_reg     <= tick_next;
            in_full_reg  <= in_full_next;
            out_full_reg <= out_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            in_pkt_reg  <= in_pkt_next;
            out_pkt_reg <= out_pkt_next;
        end
    end

endmodule

[rtl/mr1d_resbuf.sv]
module mr1d_resbuf
    import mr1d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  res_t              res_in,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_kind,
    output logic              out_accepted,
    output logic [PORT_W-1:0] out_port,
    output logic              out_sent,
    output pkt_t              out_pkt,
    output logic              out_last
);

    res_t              res_reg;
    logic              valid_reg;
    logic [PIDX_W-1:0] idx_reg;

    assign out_valid    = valid_reg;
    assign out_kind     = res_reg.tick;
    assign out_last     = !res_reg.tick || (idx_reg == PIDX_W'(NPORTS - 1));
    assign out_accepted = res_reg.tick ? 1'b0 : res_reg.accepted;
    assign out_port     = res_reg.tick ? PORT_W'(idx_reg) : res_reg.port;
    assign out_sent     = res_reg.tick && res_reg.sent[idx_reg];
    assign out_pkt      = res_reg.tick ? res_reg.pkt[idx_reg] : '0;
    assign free         = !valid_reg || (out_ready && out_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (valid_reg && out_ready)
        begin
            if (out_last)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_in;
    end

endmodule

[rtl/mr1d_checker.sv]
module mr1d_checker
    import mr1d_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [IN_TDATA_W-1:0]  s_tdata,
    input logic                   s_tuser,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tuser,
    input logic                   m_tlast,
    input logic                   psel,
    input logic                   penable,
    input logic                   pwrite,
    input logic [ADDR_W-1:0]      paddr,
    input logic [31:0]            pwdata,
    input logic [31:0]            prdata,
    input logic                   pready
);

    // receive status is always a single result
    a_recv_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_RECV) |-> m_tlast)
        else $error("receive status without last");

    // idle tick slot carries no packet
    a_idle_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_TICK) && !m_tdata[4] |-> (m_tdata[116:5] == '0))
        else $error("tick slot with no packet carries data");

    // tick slots follow each other in port order without gaps
    a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && (m_tuser == KIND_TICK) && !m_tlast
        |=> m_tvalid && (m_tuser == KIND_TICK)
            && (m_tdata[3:1] == 3'($past(m_tdata[3:1]) + 3'd1)))
        else $error("tick slots out of order");

    // the final slot of a tick is the right link
    a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_TICK) && m_tlast |-> (m_tdata[3:1] == 3'(NPORTS - 1)))
        else $error("tick ended on wrong port");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind mesh1d_router_node_top mr1d_checker u_mr1d_checker (.*);
